/* rtl/ertk_pkg.sv */
// ertk_pkg: shared types and constants for the event rate alarm and column tracker
// no dependencies; imported by every module of the block

package ertk_pkg;

    // default number of column bins
    localparam int NUM_COLUMNS_DEF = 8;

    // field widths
    localparam int X_W     = 7;
    localparam int BIN_W   = 8;
    localparam int RATE_W  = 7;
    localparam int SEQ_W   = 4;
    localparam int POS_W   = 3;
    localparam int EVT_W   = 4;
    localparam int BATCH_W = 5;
    localparam int LEAK_W  = 3;
    localparam int DCNT_W  = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // x coordinate to column bin
    localparam int BIN_LSB = 4;

    // largest batch, smallest batch
    localparam logic [BATCH_W-1:0] MAX_BATCH = 5'd16;
    localparam logic [BATCH_W-1:0] MIN_BATCH = 5'd1;

    // register reset values
    localparam logic [BATCH_W-1:0] BATCH_SIZE_RST = 5'd4;
    localparam logic [LEAK_W-1:0]  LEAK_SHIFT_RST = 3'd3;
    localparam logic [RATE_W-1:0]  ALARM_THR_RST  = 7'd24;
    localparam logic [RATE_W-1:0]  RATE_CAP_RST   = 7'd127;
    localparam logic [BIN_W-1:0]   BIN_CAP_RST    = 8'd255;
    localparam logic [DCNT_W-1:0]  DECAY_PER_RST  = 8'd32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATCH_SIZE  = 3'd0,
        CFG_LEAK_SHIFT  = 3'd1,
        CFG_ALARM_THR   = 3'd2,
        CFG_RATE_CAP    = 3'd3,
        CFG_BIN_CAP     = 3'd4,
        CFG_DECAY_PER   = 3'd5
    } cfg_idx_t;

    // control from the sequencer to the peak tracker
    typedef struct packed {
        logic clear;
        logic sample;
    } peak_ctl_t;

endpackage

/* rtl/ertk_bin_mem.sv */
// ertk_bin_mem: column bin storage, one write and one registered read port
// depends on ertk_pkg; per-entry valid bits give the all-zero reset contents

module ertk_bin_mem #(
    parameter int NUM_COLUMNS = ertk_pkg::NUM_COLUMNS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [$clog2(NUM_COLUMNS)-1:0]        rd_addr,
    output logic [ertk_pkg::BIN_W-1:0]            rd_data,
    input  logic                                  wr_en,
    input  logic [$clog2(NUM_COLUMNS)-1:0]        wr_addr,
    input  logic [ertk_pkg::BIN_W-1:0]            wr_data
);
    import ertk_pkg::*;

    logic [BIN_W-1:0]       mem [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0] vld_reg;
    logic [BIN_W-1:0]       rd_q_reg;
    logic                   rd_vld_reg;

    // storage array and read register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // written-entry flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_vld_reg ? rd_q_reg : '0;

endmodule

/* rtl/ertk_peak.sv */
// ertk_peak: running argmax over the bins seen during the batch-end scan
// depends on ertk_pkg; strictly greater wins, so the lowest index keeps a tie

module ertk_peak #(
    parameter int NUM_COLUMNS = ertk_pkg::NUM_COLUMNS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ertk_pkg::peak_ctl_t             ctl,
    input  logic [$clog2(NUM_COLUMNS)-1:0]  idx,
    input  logic [ertk_pkg::BIN_W-1:0]      value,
    output logic [$clog2(NUM_COLUMNS)-1:0]  pos
);
    import ertk_pkg::*;

    localparam int COL_W = $clog2(NUM_COLUMNS);

    logic [BIN_W-1:0] peak_reg;
    logic [COL_W-1:0] pos_reg;

    // compare and capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            priority if (ctl.clear)
            begin
                peak_reg <= '0;
                pos_reg  <= '0;
            end
            else if (ctl.sample && (value > peak_reg))
            begin
                peak_reg <= value;
                pos_reg  <= idx;
            end
        end
    end

    assign pos = pos_reg;

endmodule

/* rtl/event_rate_alarm_column_tracker.sv */
// event_rate_alarm_column_tracker: leaky event rate alarm with column argmax tracking
// each event reads then writes back its bin; a batch-end event adds a scan of every bin
// a new event is taken only in idle, after the previous event's bin update, scan and emit are done
// the batch-end scan reads every bin, and rewrites each halved when decay is due, through the single memory port pair
// reset: all counters, integrator, progress and bins read as zero; registers take defaults
// depends on ertk_pkg, ertk_bin_mem, ertk_peak

module event_rate_alarm_column_tracker #(
    parameter int NUM_COLUMNS = ertk_pkg::NUM_COLUMNS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [ertk_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [ertk_pkg::CFG_DATA_W-1:0]     cfg_data,
    // event input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ertk_pkg::X_W-1:0]            x_coord,
    // status output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ertk_pkg::SEQ_W-1:0]          batch_seq,
    output logic [ertk_pkg::POS_W-1:0]          progress,
    output logic [ertk_pkg::POS_W-1:0]          position,
    output logic [ertk_pkg::RATE_W-1:0]         rate,
    output logic                                alarm
);
    import ertk_pkg::*;

    localparam int COL_W = $clog2(NUM_COLUMNS);
    localparam int CNT_W = $clog2(NUM_COLUMNS + 1);
    localparam logic [POS_W:0]   LAST_COL = (POS_W+1)'(NUM_COLUMNS - 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(NUM_COLUMNS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [BATCH_W-1:0] batch_size_reg;
    logic [LEAK_W-1:0]  leak_shift_reg;
    logic [RATE_W-1:0]  alarm_thr_reg;
    logic [RATE_W-1:0]  rate_cap_reg;
    logic [BIN_W-1:0]   bin_cap_reg;
    logic [DCNT_W-1:0]  decay_per_reg;

    // block state
    logic [RATE_W-1:0]  rate_reg;
    logic [EVT_W-1:0]   evt_cnt_reg;
    logic [DCNT_W-1:0]  decay_cnt_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [POS_W-1:0]   progress_reg;
    logic [COL_W-1:0]   col_reg;
    logic               decay_now_reg;
    logic [CNT_W-1:0]   scan_cnt_reg;

    // output register
    logic               out_valid_reg;
    logic [SEQ_W-1:0]   batch_seq_reg;
    logic [POS_W-1:0]   progress_out_reg;
    logic [POS_W-1:0]   position_reg;
    logic [RATE_W-1:0]  rate_out_reg;
    logic               alarm_reg;

    // memory and peak tracker connections
    logic               mem_rd_en;
    logic [COL_W-1:0]   mem_rd_addr;
    logic [BIN_W-1:0]   mem_rd_data;
    logic               mem_we;
    logic [COL_W-1:0]   mem_wr_addr;
    logic [BIN_W-1:0]   mem_wr_data;
    peak_ctl_t          peak_ctl;
    logic [COL_W-1:0]   peak_pos;

    // combinational helpers
    logic               in_beat;
    logic [POS_W:0]     col_raw;
    logic [POS_W:0]     col_lim;
    logic [COL_W-1:0]   col_in;
    logic [BIN_W-1:0]   bin_inc;
    logic [RATE_W-1:0]  rate_inc;
    logic [RATE_W-1:0]  rate_leak;
    logic [BATCH_W-1:0] eff_batch;
    logic [BATCH_W-1:0] evt_nx;
    logic               batch_end;
    logic [DCNT_W-1:0]  dcnt_inc;
    logic               decay_hit;
    logic [CNT_W-1:0]   scan_prev;
    logic [COL_W-1:0]   scan_idx;
    logic [BIN_W-1:0]   scan_val;
    logic               scan_proc;
    logic               scan_rd;
    logic               out_free;
    logic               emit_load;
    logic [POS_W-1:0]   pos_ext;

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;

    // column bin of the incoming event, clamped to the last bin
    assign col_raw = {1'b0, x_coord[X_W-1:BIN_LSB]};
    assign col_lim = (col_raw > LAST_COL) ? LAST_COL : col_raw;
    assign col_in  = col_lim[COL_W-1:0];

    // saturating increments
    assign bin_inc  = (mem_rd_data < bin_cap_reg) ? (mem_rd_data + 8'd1) : mem_rd_data;
    assign rate_inc = (rate_reg < rate_cap_reg) ? (rate_reg + 7'd1) : rate_reg;
    assign rate_leak = rate_inc - (rate_inc >> leak_shift_reg);

    // batch boundary
    always_comb
    begin
        priority if (batch_size_reg == '0)
        begin
            eff_batch = MIN_BATCH;
        end
        else if (batch_size_reg > MAX_BATCH)
        begin
            eff_batch = MAX_BATCH;
        end
        else
        begin
            eff_batch = batch_size_reg;
        end
    end
    assign evt_nx    = {1'b0, evt_cnt_reg} + 5'd1;
    assign batch_end = !(evt_nx < eff_batch);
    assign dcnt_inc  = decay_cnt_reg + 8'd1;
    assign decay_hit = (dcnt_inc >= decay_per_reg);

    // scan pipeline: read bin n while bin n-1 comes back
    assign scan_rd   = (state_reg == S_SCAN) && (scan_cnt_reg != SCAN_END);
    assign scan_proc = (state_reg == S_SCAN) && (scan_cnt_reg != '0);
    assign scan_prev = scan_cnt_reg - CNT_W'(1);
    assign scan_idx  = scan_prev[COL_W-1:0];
    assign scan_val  = decay_now_reg ? (mem_rd_data >> 1) : mem_rd_data;

    // memory port control
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = col_in;
        mem_we      = 1'b0;
        mem_wr_addr = col_reg;
        mem_wr_data = bin_inc;
        if (in_beat)
        begin
            mem_rd_en = 1'b1;
        end
        if (scan_rd)
        begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = scan_cnt_reg[COL_W-1:0];
        end
        if (state_reg == S_UPD)
        begin
            mem_we = 1'b1;
        end
        if (scan_proc && decay_now_reg)
        begin
            mem_we      = 1'b1;
            mem_wr_addr = scan_idx;
            mem_wr_data = scan_val;
        end
    end

    // peak tracker control
    assign peak_ctl.clear  = (state_reg == S_UPD);
    assign peak_ctl.sample = scan_proc;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_load = (state_reg == S_EMIT) && out_free;
    assign pos_ext   = POS_W'(peak_pos);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_size_reg <= BATCH_SIZE_RST;
            leak_shift_reg <= LEAK_SHIFT_RST;
            alarm_thr_reg  <= ALARM_THR_RST;
            rate_cap_reg   <= RATE_CAP_RST;
            bin_cap_reg    <= BIN_CAP_RST;
            decay_per_reg  <= DECAY_PER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_BATCH_SIZE: batch_size_reg <= cfg_data[BATCH_W-1:0];
                CFG_LEAK_SHIFT: leak_shift_reg <= cfg_data[LEAK_W-1:0];
                CFG_ALARM_THR:  alarm_thr_reg  <= cfg_data[RATE_W-1:0];
                CFG_RATE_CAP:   rate_cap_reg   <= cfg_data[RATE_W-1:0];
                CFG_BIN_CAP:    bin_cap_reg    <= cfg_data[BIN_W-1:0];
                CFG_DECAY_PER:  decay_per_reg  <= cfg_data[DCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer, block state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            rate_reg         <= '0;
            evt_cnt_reg      <= '0;
            decay_cnt_reg    <= '0;
            seq_reg          <= '0;
            progress_reg     <= '0;
            col_reg          <= '0;
            decay_now_reg    <= 1'b0;
            scan_cnt_reg     <= '0;
            out_valid_reg    <= 1'b0;
            batch_seq_reg    <= '0;
            progress_out_reg <= '0;
            position_reg     <= '0;
            rate_out_reg     <= '0;
            alarm_reg        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !emit_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                    begin
                        col_reg   <= col_in;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (batch_end)
                    begin
                        evt_cnt_reg   <= '0;
                        rate_reg      <= rate_leak;
                        decay_now_reg <= decay_hit;
                        decay_cnt_reg <= decay_hit ? '0 : dcnt_inc;
                        scan_cnt_reg  <= '0;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        evt_cnt_reg <= evt_nx[EVT_W-1:0];
                        rate_reg    <= rate_inc;
                        state_reg   <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                    if (scan_cnt_reg == SCAN_END)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        seq_reg          <= seq_reg + 4'd1;
                        progress_reg     <= (pos_ext > progress_reg) ? pos_ext : progress_reg;
                        out_valid_reg    <= 1'b1;
                        batch_seq_reg    <= seq_reg + 4'd1;
                        progress_out_reg <= (pos_ext > progress_reg) ? pos_ext : progress_reg;
                        position_reg     <= pos_ext;
                        rate_out_reg     <= rate_reg;
                        alarm_reg        <= (rate_reg > alarm_thr_reg);
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // bin storage
    ertk_bin_mem #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_bin_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // argmax over the scan
    ertk_peak #(
        .NUM_COLUMNS (NUM_COLUMNS)
    ) u_peak (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (peak_ctl),
        .idx   (scan_idx),
        .value (scan_val),
        .pos   (peak_pos)
    );

    assign out_valid = out_valid_reg;
    assign batch_seq = batch_seq_reg;
    assign progress  = progress_out_reg;
    assign position  = position_reg;
    assign rate      = rate_out_reg;
    assign alarm     = alarm_reg;

    // an accepted beat is always followed by its bin update
    a_beat_to_upd: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == S_UPD))
        else $error("accepted beat did not move to bin update");

    // the bin memory is never written while waiting for an event
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("bin write while idle");

    // progress is a ratchet
    a_progress_ratchet: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (progress_reg >= $past(progress_reg)))
        else $error("progress went backwards");

    // scan counter stays within the bin range
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_cnt_reg <= SCAN_END))
        else $error("scan counter out of range");

    // a new status beat is loaded only when the output register is free
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(batch_seq_reg)))
        else $error("pending status beat overwritten");

endmodule
